[design/mqbf_pkg.sv]
`default_nettype none

package mqbf_pkg;

    localparam int NUM_QUEUES = 8;
    localparam int MAX_DEPTH  = 64;

    // fixed field widths of the item and result
    localparam int MODE_W   = 3;
    localparam int HANDLE_W = 3;
    localparam int DATA_W   = 8;
    localparam int CNT_W    = 7;
    localparam int LIMIT_W  = 4;
    localparam int OPEN_W   = 4;

    localparam int PTR_W  = $clog2(MAX_DEPTH);
    localparam int ADDR_W = $clog2(NUM_QUEUES * MAX_DEPTH);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC       = 3'd0,
        MODE_PUSH        = 3'd1,
        MODE_POP         = 3'd2,
        MODE_RELEASE     = 3'd3,
        MODE_RELEASE_ALL = 3'd4,
        MODE_QUERY       = 3'd5
    } t_mode;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic                status;
        logic [HANDLE_W-1:0] handle;
        logic                pop_ok;
        logic [CNT_W-1:0]    fill;
        logic [CNT_W-1:0]    depth;
        logic [OPEN_W-1:0]   open_cnt;
    } t_result;

endpackage

`default_nettype wire

[design/mqbf_store.sv]
`default_nettype none

module mqbf_store (
    input  wire                         i_clk,
    input  wire mqbf_pkg::t_mem_req     i_req,
    output logic [mqbf_pkg::DATA_W-1:0] o_rdata
);

    logic [mqbf_pkg::DATA_W-1:0] r_mem [mqbf_pkg::NUM_QUEUES * mqbf_pkg::MAX_DEPTH];
    logic [mqbf_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/mqbf_ctrl.sv]
`default_nettype none

module mqbf_ctrl (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [mqbf_pkg::LIMIT_W-1:0]   i_cfg_limit,
    input  wire                           i_process,
    input  wire [mqbf_pkg::MODE_W-1:0]    i_mode,
    input  wire [mqbf_pkg::HANDLE_W-1:0]  i_handle,
    input  wire [mqbf_pkg::DATA_W-1:0]    i_data,
    input  wire [mqbf_pkg::CNT_W-1:0]     i_depth,
    output mqbf_pkg::t_mem_req            o_mem,
    output mqbf_pkg::t_result             o_result
);

    logic [mqbf_pkg::LIMIT_W-1:0]  r_limit;
    logic [mqbf_pkg::NUM_QUEUES-1:0] r_open;
    logic [mqbf_pkg::OPEN_W-1:0]   r_total;
    logic [mqbf_pkg::PTR_W-1:0]    r_rp    [mqbf_pkg::NUM_QUEUES];
    logic [mqbf_pkg::PTR_W-1:0]    r_wp    [mqbf_pkg::NUM_QUEUES];
    logic [mqbf_pkg::CNT_W-1:0]    r_fill  [mqbf_pkg::NUM_QUEUES];
    logic [mqbf_pkg::CNT_W-1:0]    r_depth [mqbf_pkg::NUM_QUEUES];

    logic [mqbf_pkg::NUM_QUEUES-1:0] n_open;
    logic [mqbf_pkg::OPEN_W-1:0]   n_total;
    logic [mqbf_pkg::PTR_W-1:0]    n_rp;
    logic [mqbf_pkg::PTR_W-1:0]    n_wp;
    logic [mqbf_pkg::CNT_W-1:0]    n_fill;
    logic [mqbf_pkg::CNT_W-1:0]    n_depth;

    logic [mqbf_pkg::LIMIT_W-1:0]  lim;
    logic [mqbf_pkg::NUM_QUEUES-1:0] usable;
    logic                          free_found;
    logic [mqbf_pkg::HANDLE_W-1:0] free_idx;
    logic                          h_ok;
    logic                          depth_ok;
    logic                          cur_open;
    logic [mqbf_pkg::PTR_W-1:0]    cur_rp;
    logic [mqbf_pkg::PTR_W-1:0]    cur_wp;
    logic [mqbf_pkg::CNT_W-1:0]    cur_fill;
    logic [mqbf_pkg::CNT_W-1:0]    cur_depth;
    logic [mqbf_pkg::CNT_W-1:0]    rp_inc;
    logic [mqbf_pkg::CNT_W-1:0]    wp_inc;
    logic                          slot_we;
    logic [mqbf_pkg::HANDLE_W-1:0] slot_idx;
    logic                          push_ok;
    logic                          shape_bad;

    // effective limit is min(queue_limit, NUM_QUEUES)
    assign lim = (r_limit > mqbf_pkg::LIMIT_W'(mqbf_pkg::NUM_QUEUES))
               ? mqbf_pkg::LIMIT_W'(mqbf_pkg::NUM_QUEUES) : r_limit;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = mqbf_pkg::NUM_QUEUES - 1; s >= 0; s--) begin
            usable[s] = (mqbf_pkg::LIMIT_W'(s) < lim);
            if (usable[s] && !r_open[s]) begin
                free_found = 1'b1;
                free_idx   = mqbf_pkg::HANDLE_W'(s);
            end
        end
    end

    assign h_ok      = ({1'b0, i_handle} < lim);
    assign depth_ok  = (i_depth != '0) && (i_depth <= mqbf_pkg::CNT_W'(mqbf_pkg::MAX_DEPTH));
    assign cur_open  = r_open[i_handle];
    assign cur_rp    = r_rp[i_handle];
    assign cur_wp    = r_wp[i_handle];
    assign cur_fill  = r_fill[i_handle];
    assign cur_depth = r_depth[i_handle];
    assign rp_inc    = {1'b0, cur_rp} + mqbf_pkg::CNT_W'(1);
    assign wp_inc    = {1'b0, cur_wp} + mqbf_pkg::CNT_W'(1);

    always_comb begin
        n_open   = r_open;
        n_total  = r_total;
        n_rp     = cur_rp;
        n_wp     = cur_wp;
        n_fill   = cur_fill;
        n_depth  = cur_depth;
        slot_we  = 1'b0;
        slot_idx = i_handle;
        push_ok  = 1'b0;
        o_result = '0;
        o_result.status = 1'b1;

        if (i_mode == mqbf_pkg::MODE_ALLOC) begin
            if (depth_ok && free_found) begin
                n_open[free_idx] = 1'b1;
                n_total          = r_total + mqbf_pkg::OPEN_W'(1);
                slot_we          = 1'b1;
                slot_idx         = free_idx;
                n_rp             = '0;
                n_wp             = '0;
                n_fill           = '0;
                n_depth          = i_depth;
                o_result.status  = 1'b0;
                o_result.handle  = free_idx;
                o_result.depth   = i_depth;
            end
        end else if (i_mode == mqbf_pkg::MODE_RELEASE_ALL) begin
            n_open          = '0;
            n_total         = '0;
            o_result.status = 1'b0;
        end else if (h_ok && cur_open) begin
            o_result.fill  = cur_fill;
            o_result.depth = cur_depth;
            case (i_mode)
                mqbf_pkg::MODE_PUSH: begin
                    if (cur_fill < cur_depth) begin
                        push_ok         = 1'b1;
                        slot_we         = 1'b1;
                        n_wp            = (wp_inc >= cur_depth) ? '0 : wp_inc[mqbf_pkg::PTR_W-1:0];
                        n_fill          = cur_fill + mqbf_pkg::CNT_W'(1);
                        o_result.status = 1'b0;
                        o_result.fill   = n_fill;
                    end
                end
                mqbf_pkg::MODE_POP: begin
                    if (cur_fill != '0) begin
                        slot_we         = 1'b1;
                        n_rp            = (rp_inc >= cur_depth) ? '0 : rp_inc[mqbf_pkg::PTR_W-1:0];
                        n_fill          = cur_fill - mqbf_pkg::CNT_W'(1);
                        o_result.status = 1'b0;
                        o_result.pop_ok = 1'b1;
                        o_result.fill   = n_fill;
                    end
                end
                mqbf_pkg::MODE_RELEASE: begin
                    n_open[i_handle] = 1'b0;
                    n_total          = r_total - mqbf_pkg::OPEN_W'(1);
                    o_result.status  = 1'b0;
                    o_result.fill    = '0;
                    o_result.depth   = '0;
                end
                mqbf_pkg::MODE_QUERY: begin
                    o_result.status = 1'b0;
                end
                default: begin
                    // unused modes report like a query but fail
                    o_result.status = 1'b1;
                end
            endcase
        end
        o_result.open_cnt = n_total;
    end

    always_comb begin
        o_mem.we    = i_process && push_ok;
        o_mem.waddr = mqbf_pkg::ADDR_W'(i_handle) * mqbf_pkg::ADDR_W'(mqbf_pkg::MAX_DEPTH)
                    + mqbf_pkg::ADDR_W'(cur_wp);
        o_mem.wdata = i_data;
        o_mem.re    = i_process;
        o_mem.raddr = mqbf_pkg::ADDR_W'(i_handle) * mqbf_pkg::ADDR_W'(mqbf_pkg::MAX_DEPTH)
                    + mqbf_pkg::ADDR_W'(cur_rp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= mqbf_pkg::LIMIT_RESET;
            r_open  <= '0;
            r_total <= '0;
        end else if (i_cfg_we) begin
            // a new limit rebuilds the pool
            r_limit <= i_cfg_limit;
            r_open  <= '0;
            r_total <= '0;
        end else if (i_process) begin
            r_open  <= n_open;
            r_total <= n_total;
        end
    end

    // per-slot pointers only matter while the slot is open
    always_ff @(posedge i_clk) begin
        if (i_process && slot_we) begin
            r_rp[slot_idx]    <= n_rp;
            r_wp[slot_idx]    <= n_wp;
            r_fill[slot_idx]  <= n_fill;
            r_depth[slot_idx] <= n_depth;
        end
    end

    always_comb begin
        shape_bad = 1'b0;
        for (int s = 0; s < mqbf_pkg::NUM_QUEUES; s++) begin
            if (r_open[s] && ((r_fill[s] > r_depth[s]) || (r_depth[s] == '0))) begin
                shape_bad = 1'b1;
            end
        end
    end

    a_total_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total == mqbf_pkg::OPEN_W'($countones(r_open)))
        else $error("open count out of step with open slots");

    a_open_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_open & ~usable) == '0)
        else $error("open slot at or above the limit");

    a_slot_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !shape_bad)
        else $error("open slot with bad fill or depth");

endmodule

`default_nettype wire

[design/multi_queue_byte_fifo_core.sv]
`default_nettype none

// an accepted item is held in the input register, then its result in the result register
// throughput: one item per cycle unless output stalls; one store read, at most one write per item
// an item is accepted while a finished result still waits for the output side, if the input register is empty
// reset (i_rst_n low, synchronous): all queues closed, open count 0, limit 8
// the byte store is not cleared; only pushed bytes are ever popped
module multi_queue_byte_fifo_core (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [mqbf_pkg::LIMIT_W-1:0]   i_cfg_wdata,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire [mqbf_pkg::MODE_W-1:0]    i_mode,
    input  wire [mqbf_pkg::HANDLE_W-1:0]  i_queue_handle,
    input  wire [mqbf_pkg::DATA_W-1:0]    i_data_in,
    input  wire [mqbf_pkg::CNT_W-1:0]     i_alloc_depth,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic                          o_status,
    output logic [mqbf_pkg::HANDLE_W-1:0] o_handle_out,
    output logic [mqbf_pkg::DATA_W-1:0]   o_data_out,
    output logic [mqbf_pkg::CNT_W-1:0]    o_fill_count,
    output logic [mqbf_pkg::CNT_W-1:0]    o_queue_depth,
    output logic [mqbf_pkg::OPEN_W-1:0]   o_open_queues
);

    logic                          r_in_valid;
    logic                          n_in_valid;
    logic [mqbf_pkg::MODE_W-1:0]   r_mode;
    logic [mqbf_pkg::HANDLE_W-1:0] r_handle;
    logic [mqbf_pkg::DATA_W-1:0]   r_data;
    logic [mqbf_pkg::CNT_W-1:0]    r_depth;
    logic                          r_out_valid;
    logic                          n_out_valid;
    mqbf_pkg::t_result             r_result;
    mqbf_pkg::t_result             result;
    mqbf_pkg::t_mem_req            mem_req;
    logic [mqbf_pkg::DATA_W-1:0]   rdata;
    logic                          process;
    logic                          in_fire;

    assign process     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || process;
    assign in_fire     = i_in_valid && o_in_ready;
    assign n_in_valid  = in_fire || (r_in_valid && !process);
    assign n_out_valid = process || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode   <= i_mode;
            r_handle <= i_queue_handle;
            r_data   <= i_data_in;
            r_depth  <= i_alloc_depth;
        end
        if (process) begin
            r_result <= result;
        end
    end

    mqbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_limit (i_cfg_wdata),
        .i_process   (process),
        .i_mode      (r_mode),
        .i_handle    (r_handle),
        .i_data      (r_data),
        .i_depth     (r_depth),
        .o_mem       (mem_req),
        .o_result    (result)
    );

    mqbf_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_result.status;
    assign o_handle_out  = r_result.handle;
    assign o_data_out    = r_result.pop_ok ? rdata : '0;
    assign o_fill_count  = r_result.fill;
    assign o_queue_depth = r_result.depth;
    assign o_open_queues = r_result.open_cnt;

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_result)))
        else $error("stalled result changed");

    a_input_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !o_in_ready) |-> (r_out_valid && !i_out_ready))
        else $error("input stalled without output back-pressure");

    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_data_out == '0 && o_handle_out == '0))
        else $error("failed item carries data or handle");

endmodule

`default_nettype wire
